@@ design/stn_pkg.sv @@
// Shared constants and elaboration-time sine table functions for the tone generator.
package stn_pkg;

   // Sample and register widths
   localparam int SAMPLE_BITS = 8;
   localparam int STEP_BITS   = 32;
   localparam int DATA_BITS   = 8;

   // pi in Q48 and unity in Q30
   localparam logic [127:0] PI_Q48  = 128'h3243F6A8885A3;
   localparam logic [127:0] ONE_Q30 = 128'd1 << 30;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   // |sin(2*pi*q/N)| in Q30 for quarter index q in [0, N/4], Taylor series to x^19
   function automatic logic [127:0] quarter_sine(input int unsigned q, input int unsigned ab);
      logic [127:0] x;
      logic [127:0] x2;
      logic [127:0] term;
      logic [127:0] pos;
      logic [127:0] neg;
      logic [127:0] quarter;
      quarter = (128'd1 << ab) >> 2;
      if (q == 0) begin
         return 128'd0;
      end
      if (128'(q) >= quarter) begin
         return ONE_Q30;
      end
      x    = (PI_Q48 * (128'd2 * 128'(q)) + (128'd1 << (17 + ab))) >> (18 + ab);
      x2   = (x * x) >> 30;
      pos  = x;
      neg  = 128'd0;
      term = ((x * x2) >> 30) / 128'd6;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 128'd20;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 128'd42;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 128'd72;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 128'd110;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 128'd156;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 128'd210;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 128'd272;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 128'd342;
      neg  = neg + term;
      pos  = (pos > neg) ? pos - neg : 128'd0;
      return (pos > ONE_Q30) ? ONE_Q30 : pos;
   endfunction

   // One table entry: round(127.5 + 127.5*sin(2*pi*i/N)), built by quarter-wave symmetry
   function automatic sample_type sine_entry(input int unsigned i, input int unsigned ab);
      int unsigned  n;
      int unsigned  q;
      logic         negative;
      logic [127:0] m;
      logic [127:0] whole;
      n = 32'd1 << ab;
      if (i < n / 4) begin
         q = i;
         negative = 1'b0;
      end else if (i < n / 2) begin
         q = n / 2 - i;
         negative = 1'b0;
      end else if (i < 3 * (n / 4)) begin
         q = i - n / 2;
         negative = 1'b1;
      end else begin
         q = n - i;
         negative = 1'b1;
      end
      m     = 128'd255 * quarter_sine(q, ab);
      whole = m >> 31;
      if (negative) begin
         if (m[30:0] != 31'd0) begin
            whole = whole + 128'd1;
         end
         return (whole >= 128'd128) ? sample_type'(0) : sample_type'(128'd128 - whole);
      end
      return (whole >= 128'd127) ? sample_type'(255) : sample_type'(128'd128 + whole);
   endfunction

endpackage

@@ design/sine_tone_generator_core.sv @@
// Sine tone generator: every accepted request yields one unsigned 8-bit sine sample.
// Each request on req_ returns exactly one sample on rsp_, in order, taken from a
// 2^TABLE_ADDR_BITS-entry sine table at the top bits of a PHASE_BITS-wide phase
// accumulator; the accumulator then advances by the step written on csr_ (saturated
// at half a turn). Requests are taken one per cycle while req_tready is high; a sample
// passes the ROM read register, then the output register, and a new request is
// still taken while one finished sample waits for rsp_tready. Bit 0 of req_tdata comes
// back as rsp_tlast. Write csr_ only while no request is outstanding.
module sine_tone_generator_core
   import stn_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [STEP_BITS-1:0] csr_wdata,     // phase_step
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_BITS-1:0] req_tdata,     // [0] end_of_buffer, [7:1] zero
   // result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_BITS-1:0] rsp_tdata,     // [7:0] sample
   output logic                 rsp_tlast      // last
);

   logic                       req_accept;
   logic                       out_load;
   logic [TABLE_ADDR_BITS-1:0] table_addr;
   sample_type                 rom_data;

   logic       rd_valid_ff;
   logic       rd_valid_in;
   logic       rd_last_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       out_last_ff;
   sample_type out_sample_ff;

   stn_phase_acc #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .advance    (req_accept),
      .table_addr (table_addr)
   );

   stn_sine_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock      (clock),
      .rd_en      (req_accept),
      .rd_addr    (table_addr),
      .rd_data_ff (rom_data)
   );

   // handshake: read stage moves on when the output register is free or drains
   assign out_load   = rd_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !rd_valid_ff || out_load;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (req_accept) begin
         rd_valid_in = 1'b1;
      end else if (out_load) begin
         rd_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_last_ff <= req_tdata[0];
      end
      if (out_load) begin
         out_sample_ff <= rom_data;
         out_last_ff   <= rd_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = DATA_BITS'(out_sample_ff);
   assign rsp_tlast  = out_last_ff;

   // an accepted request always lands in the read stage
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rd_valid_ff)
      else $error("accepted request not held in read stage");

   // a pending read result moves into a free output register
   a_out_fills: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && !out_valid_ff |=> out_valid_ff)
      else $error("output register did not take pending sample");

   // a stalled read stage keeps its request
   a_rd_holds: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff && out_valid_ff && !rsp_tready |=> rd_valid_ff && $stable(rd_last_ff))
      else $error("read stage lost a stalled request");

endmodule

@@ design/stn_phase_acc.sv @@
// Phase step register with half-turn saturation and the wrapping phase accumulator.
module stn_phase_acc
   import stn_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [STEP_BITS-1:0]       csr_wdata,
   input  logic                       advance,
   output logic [TABLE_ADDR_BITS-1:0] table_addr
);

   localparam int CmpBits = (PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS + 1;
   localparam logic [CmpBits-1:0] HalfTurn = CmpBits'(1) << (PHASE_BITS - 1);

   logic [PHASE_BITS-1:0] step_ff;
   logic [PHASE_BITS-1:0] step_in;
   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] acc_in;
   logic [CmpBits-1:0]    wdata_ext;

   // saturate the step at half a turn when it is written
   always_comb begin
      wdata_ext = CmpBits'(csr_wdata);
      step_in   = step_ff;
      if (csr_we) begin
         step_in = (wdata_ext > HalfTurn) ? PHASE_BITS'(HalfTurn) : PHASE_BITS'(wdata_ext);
      end
   end

   // accumulator advances once per accepted request, wrapping
   assign acc_in = advance ? acc_ff + step_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         acc_ff  <= '0;
      end else begin
         step_ff <= step_in;
         acc_ff  <= acc_in;
      end
   end

   // table index is the top bits of the current phase
   assign table_addr = acc_ff[PHASE_BITS-1 -: TABLE_ADDR_BITS];

endmodule

@@ design/stn_sine_rom.sv @@
// Full-wave sine ROM built at elaboration, with a registered read port.
module stn_sine_rom
   import stn_pkg::*;
#(
   parameter int TABLE_ADDR_BITS = 10
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [TABLE_ADDR_BITS-1:0] rd_addr,
   output sample_type                 rd_data_ff
);

   localparam int TableSize = 1 << TABLE_ADDR_BITS;

   typedef sample_type rom_type [TableSize];

   function automatic rom_type build_rom();
      rom_type t;
      for (int i = 0; i < TableSize; i++) begin
         t[i] = sine_entry(i, TABLE_ADDR_BITS);
      end
      return t;
   endfunction

   localparam rom_type SineTable = build_rom();

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= SineTable[rd_addr];
      end
   end

endmodule
